/* design/servo_drive_enable_sequencer_top_macros.svh */
// ----------------------------------------------------------------------------
// Servo drive enable sequencer assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef SERVO_DRIVE_ENABLE_SEQUENCER_TOP_MACROS_SVH
`define SERVO_DRIVE_ENABLE_SEQUENCER_TOP_MACROS_SVH

// Check an expression at every clock edge outside reset
`define SDES_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// Check a consequence in the cycle after an antecedent
`define SDES_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/sdes_pkg.sv */
// ----------------------------------------------------------------------------
// Servo drive enable sequencer package
// Drive state codes, control word values, beat types and fixed constants.
// ----------------------------------------------------------------------------
package sdes_pkg;

    // Decoded drive state, as reported on the result beat
    typedef enum logic [3:0] {
        ST_UNKNOWN  = 4'd0,
        ST_SOD      = 4'd1,
        ST_READY    = 4'd2,
        ST_SWON     = 4'd3,
        ST_OPER     = 4'd4,
        ST_FREACT   = 4'd5,
        ST_FAULT    = 4'd6,
        ST_DISABLED = 4'd7,
        ST_RESET    = 4'd8
    } drive_state_t;

    // Control word values
    localparam logic [15:0] CW_DISABLE     = 16'h0000;
    localparam logic [15:0] CW_SHUTDOWN    = 16'h0006;
    localparam logic [15:0] CW_SWITCH_ON   = 16'h0007;
    localparam logic [15:0] CW_ENABLE_OP   = 16'h000F;
    localparam logic [15:0] CW_FAULT_RESET = 16'h0080;

    // Status word masks and patterns
    localparam logic [15:0] SW_MASK_LOW    = 16'h000F;
    localparam logic [15:0] SW_MASK_SOD    = 16'h004F;
    localparam logic [15:0] SW_MASK_RUN    = 16'h006F;
    localparam logic [15:0] SW_PAT_FAULT   = 16'h0008;
    localparam logic [15:0] SW_PAT_FREACT  = 16'h000F;
    localparam logic [15:0] SW_PAT_SOD     = 16'h0040;
    localparam logic [15:0] SW_PAT_READY   = 16'h0021;
    localparam logic [15:0] SW_PAT_SWON    = 16'h0023;
    localparam logic [15:0] SW_PAT_OPER    = 16'h0027;

    // Fixed outputs
    localparam logic [7:0]  OP_MODE_PROFILE_VEL = 8'd3;
    localparam logic [15:0] PROFILE_ACCEL       = 16'd700;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_VELOCITY_RPM   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNTS_PER_REV = 2'd1;

    localparam logic signed [15:0] RPM_RESET = 16'sd0;
    localparam logic [31:0]        CPR_RESET = 32'd1048576;

    // Register stages in the velocity unit
    localparam int unsigned VEL_LATENCY = 5;
    localparam int unsigned SETTLE_W    = $clog2(VEL_LATENCY + 1);

    // Commands carried on one input beat
    typedef struct packed {
        logic enable;
        logic disable_drv;
        logic fault_reset;
        logic start;
        logic stop;
    } sdes_cmd_t;

    // One input beat
    typedef struct packed {
        logic [15:0]        status_word;
        logic signed [31:0] actual_position;
        sdes_cmd_t          cmd;
    } sdes_item_t;

    // Sequencer state, which is also the result beat
    typedef struct packed {
        logic               pending;
        logic [15:0]        control;
        logic signed [31:0] velocity;
        logic signed [31:0] position;
        drive_state_t       drive_state;
    } sdes_state_t;

endpackage

/* design/sdes_vel_unit.sv */
// ----------------------------------------------------------------------------
// Servo drive enable sequencer velocity unit
// Pipelined rpm * counts_per_rev / 60, truncated toward zero and saturated.
// ----------------------------------------------------------------------------
module sdes_vel_unit
    import sdes_pkg::*;
(
    input  logic               clk,
    input  logic signed [15:0] rpm,
    input  logic [31:0]        counts_per_rev,
    output logic signed [31:0] velocity
);

    // x / 15 by reciprocal: exact for x below 2^30 and below 2^20 respectively
    localparam logic [30:0] RECIP15_WIDE   = 31'd1145324613;
    localparam int unsigned RECIP15_WIDE_SH = 34;
    localparam logic [19:0] RECIP15_NARROW = 20'd559241;
    localparam int unsigned RECIP15_NARROW_SH = 23;

    logic [60:0]        a_prod;
    logic [26:0]        a_s1_reg;
    logic [31:0]        cpr_s1_reg;
    logic [15:0]        m_s1_reg;
    logic               neg_s1_reg;

    logic [32:0]        a60;
    logic [5:0]         b_s2_reg;
    logic [42:0]        ma_s2_reg;
    logic [15:0]        m_s2_reg;
    logic               neg_s2_reg;

    logic [21:0]        mb_s3_reg;
    logic [42:0]        ma_s3_reg;
    logic               neg_s3_reg;

    logic [39:0]        r_prod;
    logic [16:0]        r_s4_reg;
    logic [42:0]        ma_s4_reg;
    logic               neg_s4_reg;

    logic [43:0]        mag;
    logic signed [31:0] vel_next;
    logic signed [31:0] vel_reg;

    // Quotient of counts_per_rev by 60: shift out 2 bits, then divide by 15
    assign a_prod = {30'd0, counts_per_rev[31:2]} * {30'd0, RECIP15_WIDE};

    // Remainder of counts_per_rev by 60, from 60 * a as two shifts
    assign a60 = {a_s1_reg, 6'd0} - {4'd0, a_s1_reg, 2'd0};

    // Fractional part: (m * b) / 60 on a narrow value
    assign r_prod = {20'd0, mb_s3_reg[21:2]} * {20'd0, RECIP15_NARROW};

    // Sum, restore sign and saturate to 32 bits
    assign mag = {1'b0, ma_s4_reg} + {27'd0, r_s4_reg};

    always_comb
    begin
        if (!neg_s4_reg)
        begin
            if (mag > 44'h0_7FFF_FFFF)
                vel_next = 32'sh7FFF_FFFF;
            else
                vel_next = signed'(mag[31:0]);
        end
        else
        begin
            if (mag > 44'h0_8000_0000)
                vel_next = 32'sh8000_0000;
            else
                vel_next = signed'(32'd0 - mag[31:0]);
        end
    end

    // Advance the pipeline every cycle
    always_ff @(posedge clk)
    begin
        a_s1_reg   <= a_prod[RECIP15_WIDE_SH +: 27];
        cpr_s1_reg <= counts_per_rev;
        m_s1_reg   <= rpm[15] ? (~rpm + 16'd1) : rpm;
        neg_s1_reg <= rpm[15];

        b_s2_reg   <= 6'(cpr_s1_reg - a60[31:0]);
        ma_s2_reg  <= {27'd0, m_s1_reg} * {16'd0, a_s1_reg};
        m_s2_reg   <= m_s1_reg;
        neg_s2_reg <= neg_s1_reg;

        mb_s3_reg  <= {6'd0, m_s2_reg} * {16'd0, b_s2_reg};
        ma_s3_reg  <= ma_s2_reg;
        neg_s3_reg <= neg_s2_reg;

        r_s4_reg   <= r_prod[RECIP15_NARROW_SH +: 17];
        ma_s4_reg  <= ma_s3_reg;
        neg_s4_reg <= neg_s3_reg;

        vel_reg    <= vel_next;
    end

    assign velocity = vel_reg;

endmodule

/* design/sdes_step.sv */
// ----------------------------------------------------------------------------
// Servo drive enable sequencer step logic
// Status decode, enable sequencing, drive commands then motion commands.
// ----------------------------------------------------------------------------
module sdes_step
    import sdes_pkg::*;
(
    input  sdes_state_t        cur,
    input  sdes_item_t         item,
    input  logic signed [31:0] start_velocity,
    output sdes_state_t        nxt
);

    // Fault and fault reaction first, anything unmatched is unknown
    function automatic drive_state_t decode_status(input logic [15:0] s);
        drive_state_t d;
        priority if ((s & SW_MASK_LOW) == SW_PAT_FAULT)  d = ST_FAULT;
        else if ((s & SW_MASK_LOW) == SW_PAT_FREACT)     d = ST_FREACT;
        else if ((s & SW_MASK_SOD) == SW_PAT_SOD)        d = ST_SOD;
        else if ((s & SW_MASK_RUN) == SW_PAT_READY)      d = ST_READY;
        else if ((s & SW_MASK_RUN) == SW_PAT_SWON)       d = ST_SWON;
        else if ((s & SW_MASK_RUN) == SW_PAT_OPER)       d = ST_OPER;
        else                                             d = ST_UNKNOWN;
        return d;
    endfunction

    always_comb
    begin
        nxt             = cur;
        nxt.drive_state = decode_status(item.status_word);
        nxt.pending     = cur.pending | item.cmd.enable;

        // Step the control word while an enable is pending
        if (nxt.pending)
        begin
            unique case (nxt.drive_state)
                ST_OPER:
                begin
                    nxt.control = CW_ENABLE_OP;
                    nxt.pending = 1'b0;
                end
                ST_SWON:  nxt.control = CW_ENABLE_OP;
                ST_READY: nxt.control = CW_SWITCH_ON;
                ST_SOD:   nxt.control = CW_SHUTDOWN;
                default:  ;
            endcase
        end

        // Disable, then fault reset: latch position and drop velocity
        if (item.cmd.disable_drv)
        begin
            nxt.control     = CW_DISABLE;
            nxt.position    = item.actual_position;
            nxt.velocity    = 32'sd0;
            nxt.drive_state = ST_DISABLED;
        end
        if (item.cmd.fault_reset)
        begin
            nxt.control     = CW_FAULT_RESET;
            nxt.position    = item.actual_position;
            nxt.velocity    = 32'sd0;
            nxt.drive_state = ST_RESET;
        end

        // Motion commands: stop wins over start
        if (item.cmd.start)
            nxt.velocity = start_velocity;
        if (item.cmd.stop)
            nxt.velocity = 32'sd0;
    end

endmodule

/* design/servo_drive_enable_sequencer_top.sv */
// ----------------------------------------------------------------------------
// Servo drive enable sequencer top level
// Each accepted input beat is registered, stepped, and held in the result register.
// 1 beat/cycle through that path while out_ready is high and in_ready is not held.
// Reset and each config write hold in_ready low until the velocity pipeline settles.
// ----------------------------------------------------------------------------
`include "servo_drive_enable_sequencer_top_macros.svh"

module servo_drive_enable_sequencer_top
    import sdes_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_wdata,

    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [15:0]          status_word,
    input  logic signed [31:0]   actual_position,
    input  logic                 enable_request,
    input  logic                 disable_request,
    input  logic                 fault_reset_request,
    input  logic                 start_request,
    input  logic                 stop_request,

    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [15:0]          control_word,
    output logic signed [31:0]   target_velocity,
    output logic signed [31:0]   target_position,
    output logic [3:0]           drive_state,
    output logic                 enable_pending,
    output logic [7:0]           operation_mode,
    output logic [15:0]          profile_accel
);

    logic signed [15:0]  rpm_reg;
    logic [31:0]         cpr_reg;
    logic [SETTLE_W-1:0] settle_reg;
    logic [SETTLE_W-1:0] settle_next;
    logic                settled;

    logic                s1_valid_reg;
    logic                s1_valid_next;
    sdes_item_t          s1_item_reg;
    sdes_item_t          in_item;

    logic                out_valid_reg;
    logic                out_valid_next;
    sdes_state_t         st_reg;
    sdes_state_t         st_next;

    logic signed [31:0]  start_velocity;
    logic                advance;
    logic                in_fire;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rpm_reg <= RPM_RESET;
            cpr_reg <= CPR_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_VELOCITY_RPM:   rpm_reg <= signed'(cfg_wdata[15:0]);
                CFG_COUNTS_PER_REV: cpr_reg <= cfg_wdata;
                default:            ;
            endcase
        end
    end

    // Hold off input beats until the velocity pipeline reflects the config
    always_comb
    begin
        if (cfg_we)
            settle_next = SETTLE_W'(VEL_LATENCY);
        else if (!settled)
            settle_next = settle_reg - 1'b1;
        else
            settle_next = settle_reg;
    end

    assign settled = (settle_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            settle_reg <= SETTLE_W'(VEL_LATENCY);
        else
            settle_reg <= settle_next;
    end

    sdes_vel_unit u_vel (
        .clk            (clk),
        .rpm            (rpm_reg),
        .counts_per_rev (cpr_reg),
        .velocity       (start_velocity)
    );

    // Handshake: the input register advances whenever the result side can take it
    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = settled && (!s1_valid_reg || advance);
    assign in_fire  = in_valid && in_ready;

    assign s1_valid_next  = in_fire || (s1_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the input beat
    assign in_item.status_word         = status_word;
    assign in_item.actual_position     = actual_position;
    assign in_item.cmd.enable          = enable_request;
    assign in_item.cmd.disable_drv     = disable_request;
    assign in_item.cmd.fault_reset     = fault_reset_request;
    assign in_item.cmd.start           = start_request;
    assign in_item.cmd.stop            = stop_request;

    always_ff @(posedge clk)
    begin
        if (in_fire)
            s1_item_reg <= in_item;
    end

    sdes_step u_step (
        .cur            (st_reg),
        .item           (s1_item_reg),
        .start_velocity (start_velocity),
        .nxt            (st_next)
    );

    // Sequencer state doubles as the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg.pending     <= 1'b0;
            st_reg.control     <= CW_DISABLE;
            st_reg.velocity    <= 32'sd0;
            st_reg.position    <= 32'sd0;
            st_reg.drive_state <= ST_UNKNOWN;
        end
        else if (advance)
        begin
            st_reg <= st_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign control_word    = st_reg.control;
    assign target_velocity = st_reg.velocity;
    assign target_position = st_reg.position;
    assign drive_state     = st_reg.drive_state;
    assign enable_pending  = st_reg.pending;
    assign operation_mode  = OP_MODE_PROFILE_VEL;
    assign profile_accel   = PROFILE_ACCEL;

    // Checks
    `SDES_ASSERT_NEXT(a_cfg_holds_input, cfg_we, !(in_valid && in_ready), "beat accepted while velocity settles")
    `SDES_ASSERT_ALWAYS(a_pending_not_oper, !(st_reg.pending && (st_reg.drive_state == ST_OPER)), "enable still pending in operational")
    `SDES_ASSERT_ALWAYS(a_reset_cw, (st_reg.drive_state != ST_RESET) || (st_reg.control == CW_FAULT_RESET), "reset state without fault reset word")
    `SDES_ASSERT_NEXT(a_stop_zero_vel, advance && s1_item_reg.cmd.stop, st_reg.velocity == 32'sd0, "stop left velocity non-zero")

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// Servo drive enable sequencer testbench
// Sends control ticks through the valid/ready input, predicts each result beat
// with an in-bench model of the status decode, enable stepping, disable/reset
// latching and saturated velocity scaling, and checks every output field.
// Speed and encoder settings change between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sdes_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 100000;
    localparam int unsigned HOLD_AFTER   = 200;
    localparam int unsigned HOLD_CYCLES  = 80;
    localparam int unsigned MAX_PRINTS   = 20;
    localparam int unsigned PHASE_TICKS  = 63;
    localparam int unsigned IDLE_PCT     = 32;

    // Indexes that decode to no register
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 2'd3;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_wdata = '0;

    logic       in_valid  = 1'b0;
    logic       in_ready;
    sdes_item_t cur_tick  = '0;

    logic [15:0]        status_word;
    logic signed [31:0] actual_position;
    logic               enable_request;
    logic               disable_request;
    logic               fault_reset_request;
    logic               start_request;
    logic               stop_request;

    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [15:0]        control_word;
    logic signed [31:0] target_velocity;
    logic signed [31:0] target_position;
    logic [3:0]         drive_state;
    logic               enable_pending;
    logic [7:0]         operation_mode;
    logic [15:0]        profile_accel;

    // Pending ticks, and the result beats still owed by the block
    sdes_item_t  tick_queue[$];
    sdes_state_t expected_drive_out[$];
    sdes_state_t head_beat;

    // Sequencer state and settings as the bench believes them to be
    sdes_state_t        seq_now   = '{pending: 1'b0, control: CW_DISABLE, velocity: '0,
                                      position: '0, drive_state: ST_UNKNOWN};
    logic signed [15:0] model_rpm = RPM_RESET;
    logic [31:0]        model_cpr = CPR_RESET;

    bit          quiet = 1'b0;
    int unsigned hold_left;
    bit          hold_done;
    int unsigned results_seen;
    int unsigned ticks_queued = 0;
    int unsigned settings_run = 0;
    int unsigned mismatches   = 0;
    int unsigned cycles       = 0;

    assign status_word         = cur_tick.status_word;
    assign actual_position     = cur_tick.actual_position;
    assign enable_request      = cur_tick.cmd.enable;
    assign disable_request     = cur_tick.cmd.disable_drv;
    assign fault_reset_request = cur_tick.cmd.fault_reset;
    assign start_request       = cur_tick.cmd.start;
    assign stop_request        = cur_tick.cmd.stop;

    servo_drive_enable_sequencer_top dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_we              (cfg_we),
        .cfg_index           (cfg_index),
        .cfg_wdata           (cfg_wdata),
        .in_valid            (in_valid),
        .in_ready            (in_ready),
        .status_word         (status_word),
        .actual_position     (actual_position),
        .enable_request      (enable_request),
        .disable_request     (disable_request),
        .fault_reset_request (fault_reset_request),
        .start_request       (start_request),
        .stop_request        (stop_request),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .control_word        (control_word),
        .target_velocity     (target_velocity),
        .target_position     (target_position),
        .drive_state         (drive_state),
        .enable_pending      (enable_pending),
        .operation_mode      (operation_mode),
        .profile_accel       (profile_accel)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic bit chance(int unsigned pct);
        return $urandom_range(99) < pct;
    endfunction

    // Fault and fault-reaction win over the other patterns
    function automatic drive_state_t decode_status_word(logic [15:0] sw);
        if ((sw & SW_MASK_LOW) == SW_PAT_FAULT)  return ST_FAULT;
        if ((sw & SW_MASK_LOW) == SW_PAT_FREACT) return ST_FREACT;
        if ((sw & SW_MASK_SOD) == SW_PAT_SOD)    return ST_SOD;
        if ((sw & SW_MASK_RUN) == SW_PAT_READY)  return ST_READY;
        if ((sw & SW_MASK_RUN) == SW_PAT_SWON)   return ST_SWON;
        if ((sw & SW_MASK_RUN) == SW_PAT_OPER)   return ST_OPER;
        return ST_UNKNOWN;
    endfunction

    // rpm * counts / 60, truncated toward zero, clamped to 32 bits
    function automatic logic signed [31:0] rpm_to_counts_per_sec(logic signed [15:0] rpm,
                                                                 logic [31:0] cpr);
        longint prod;
        longint quot;
        prod = longint'(rpm) * longint'(cpr);
        quot = prod / 60;
        if (quot > 64'sd2147483647)  quot = 64'sd2147483647;
        if (quot < -64'sd2147483648) quot = -64'sd2147483648;
        return quot[31:0];
    endfunction

    // Advance the sequencer by one tick and return the beat it reports
    function automatic sdes_state_t step_drive_sequencer(sdes_item_t tick);
        drive_state_t st;
        st = decode_status_word(tick.status_word);
        if (tick.cmd.enable)
            seq_now.pending = 1'b1;
        if (seq_now.pending)
        begin
            case (st)
                ST_OPER:
                begin
                    seq_now.control = CW_ENABLE_OP;
                    seq_now.pending = 1'b0;
                end
                ST_SWON:  seq_now.control = CW_ENABLE_OP;
                ST_READY: seq_now.control = CW_SWITCH_ON;
                ST_SOD:   seq_now.control = CW_SHUTDOWN;
                default:  ;
            endcase
        end
        if (tick.cmd.disable_drv)
        begin
            seq_now.control  = CW_DISABLE;
            seq_now.position = tick.actual_position;
            seq_now.velocity = '0;
            st               = ST_DISABLED;
        end
        if (tick.cmd.fault_reset)
        begin
            seq_now.control  = CW_FAULT_RESET;
            seq_now.position = tick.actual_position;
            seq_now.velocity = '0;
            st               = ST_RESET;
        end
        if (tick.cmd.start)
            seq_now.velocity = rpm_to_counts_per_sec(model_rpm, model_cpr);
        if (tick.cmd.stop)
            seq_now.velocity = '0;
        seq_now.drive_state = st;
        return seq_now;
    endfunction

    // Status word with random don't-care bits that decodes to the wanted state
    function automatic logic [15:0] make_status(drive_state_t want);
        logic [15:0] r;
        r = 16'($urandom);
        case (want)
            ST_FAULT:  return (r & ~SW_MASK_LOW) | SW_PAT_FAULT;
            ST_FREACT: return r | SW_PAT_FREACT;
            ST_SOD:    return (r & ~SW_MASK_SOD) | SW_PAT_SOD;
            ST_READY:  return (r & ~SW_MASK_RUN) | SW_PAT_READY;
            ST_SWON:   return (r & ~SW_MASK_RUN) | SW_PAT_SWON;
            ST_OPER:   return (r & ~SW_MASK_RUN) | SW_PAT_OPER;
            default:   return r;
        endcase
    endfunction

    task automatic flag_mismatch(string field, logic [31:0] got, logic [31:0] want);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("[%0t] beat %0d: %s got %h want %h", $realtime, results_seen,
                     field, got, want);
    endtask

    task automatic queue_tick(logic [15:0] sw, logic [31:0] pos, logic en, logic dis,
                              logic frst, logic start, logic stop);
        sdes_item_t t;
        t.status_word     = sw;
        t.actual_position = pos;
        t.cmd             = {en, dis, frst, start, stop};
        tick_queue.push_back(t);
        ticks_queued++;
    endtask

    // Tick with random position and mostly quiet drive commands
    task automatic queue_random_tick(logic [15:0] sw, logic en, int unsigned cut_pct);
        queue_tick(sw, $urandom, en, chance(cut_pct), chance(cut_pct),
                   chance(20), chance(15));
    endtask

    // Enable sequence through the drive states, with the odd stray tick
    task automatic queue_enable_run();
        drive_state_t path[4] = '{ST_SOD, ST_READY, ST_SWON, ST_OPER};
        bit first;
        first = 1'b1;
        for (int k = 0; k < 4; k++)
        begin
            repeat ($urandom_range(1, 3))
            begin
                if (chance(10))
                    queue_random_tick(make_status(drive_state_t'($urandom_range(0, 6))),
                                      chance(10), 5);
                queue_random_tick(make_status(path[k]), first || chance(10), 4);
                first = 1'b0;
            end
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        if (idx == CFG_VELOCITY_RPM)
            model_rpm = data[15:0];
        else if (idx == CFG_COUNTS_PER_REV)
            model_cpr = data;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Hold until every tick is sent and every beat is back, then let it settle
    task automatic wait_idle();
        while (tick_queue.size() != 0 || in_valid || expected_drive_out.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic run_phase(logic signed [15:0] rpm, logic [31:0] cpr, bit no_idle);
        int unsigned phase_start;
        wait_idle();
        write_reg(CFG_VELOCITY_RPM, {16'($urandom), rpm});
        write_reg(CFG_COUNTS_PER_REV, cpr);
        settings_run++;
        quiet = no_idle;
        // Queue enable runs and stray ticks until the phase has its share
        phase_start = ticks_queued;
        while (ticks_queued - phase_start < PHASE_TICKS)
        begin
            if (chance(65))
                queue_enable_run();
            else
                queue_random_tick(16'($urandom), chance(20), 15);
        end
    endtask

    // Input side: predict on each accepted beat, then offer the next tick
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                expected_drive_out.push_back(step_drive_sequencer(cur_tick));
            if (!in_valid || in_ready)
            begin
                if (tick_queue.size() != 0 && (quiet || !chance(IDLE_PCT)))
                begin
                    cur_tick <= tick_queue.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Output side: random stalls, plus one long hold-off while ticks keep coming
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && results_seen >= HOLD_AFTER && tick_queue.size() > 16)
        begin
            out_ready <= 1'b0;
            hold_left <= HOLD_CYCLES - 1;
            hold_done <= 1'b1;
        end
        else
            out_ready <= quiet || !chance(IDLE_PCT);
    end

    // Compare each result beat with the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            results_seen <= 0;
        end
        else if (out_valid && out_ready)
        begin
            results_seen <= results_seen + 1;
            if (expected_drive_out.size() == 0)
                flag_mismatch("unexpected beat, control_word", 32'(control_word), '0);
            else
            begin
                head_beat = expected_drive_out.pop_front();
                if (control_word !== head_beat.control)
                    flag_mismatch("control_word", 32'(control_word),
                                  32'(head_beat.control));
                if (target_velocity !== head_beat.velocity)
                    flag_mismatch("target_velocity", target_velocity, head_beat.velocity);
                if (target_position !== head_beat.position)
                    flag_mismatch("target_position", target_position, head_beat.position);
                if (drive_state !== head_beat.drive_state)
                    flag_mismatch("drive_state", 32'(drive_state),
                                  32'(head_beat.drive_state));
                if (enable_pending !== head_beat.pending)
                    flag_mismatch("enable_pending", 32'(enable_pending),
                                  32'(head_beat.pending));
                if (operation_mode !== OP_MODE_PROFILE_VEL)
                    flag_mismatch("operation_mode", 32'(operation_mode),
                                  32'(OP_MODE_PROFILE_VEL));
                if (profile_accel !== PROFILE_ACCEL)
                    flag_mismatch("profile_accel", 32'(profile_accel),
                                  32'(PROFILE_ACCEL));
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d beats still owed", cycles,
                     expected_drive_out.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed ticks at 1000 rpm and the default resolution
        write_reg(CFG_VELOCITY_RPM, 32'd1000);
        write_reg(CFG_COUNTS_PER_REV, CPR_RESET);
        settings_run++;
        // enable held while the drive reports unknown, fault and fault-reaction
        queue_tick(16'h0000, 32'h7FFF_FFFF, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
        queue_tick(16'h0008, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        queue_tick(16'h000F, 32'h0000_0001, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        queue_tick(16'hFFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        queue_tick(16'hFFF8, 32'h8000_0000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        // step 6, 7, F and drop the request on operational
        queue_tick(16'h0040, 32'h0000_0010, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        queue_tick(16'hFFF0, 32'h0000_0020, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
        queue_tick(16'h0021, 32'h0000_0030, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
        queue_tick(16'h0023, 32'h0000_0040, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        queue_tick(16'h0027, 32'h0000_0050, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
        // start and stop together, then start alone
        queue_tick(16'h0027, 32'h0000_0060, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1);
        queue_tick(16'h0027, 32'h0000_0070, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
        // disable, fault reset, and both together
        queue_tick(16'h0027, 32'h8000_0000, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
        queue_tick(16'h0008, 32'h1234_5678, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0);
        queue_tick(16'h0021, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0);
        // enable and disable on one tick leaves the request pending
        queue_tick(16'h0021, 32'h7FFF_FFFF, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0);
        queue_tick(16'h0027, 32'h5555_AAAA, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        queue_tick(16'h0001, 32'hAAAA_5555, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        queue_tick(16'hFFB1, 32'h0F0F_F0F0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
        queue_tick(16'h0023, 32'hF0F0_0F0F, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0);

        // Random phases over the speed and resolution extremes
        run_phase(16'sh7FFF, 32'hFFFF_FFFF, 1'b0);
        run_phase(16'sh8000, 32'hFFFF_FFFF, 1'b0);
        run_phase(-16'sd7, 32'd61, 1'b1);
        wait_idle();
        write_reg(CFG_IDX_SPARE_LO, $urandom);
        write_reg(CFG_IDX_SPARE_HI, $urandom);
        run_phase(16'sd3000, 32'd0, 1'b0);
        run_phase(16'sd59, 32'd1, 1'b0);
        run_phase(16'($urandom), $urandom, 1'b0);
        run_phase(16'sh8000, 32'd1, 1'b0);
        run_phase(16'sd1, 32'd60, 1'b0);
        wait_idle();

        $display("%0d ticks checked over %0d speed/resolution settings", results_seen,
                 settings_run);
        $display("long output hold-off %s, %0d mismatching fields",
                 hold_done ? "exercised" : "not reached", mismatches);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
